[rtl/core/rrfo_pkg.sv]
`default_nettype none

package rrfo_pkg;

  // Frame geometry and fixed-point format
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // Register and field widths
  localparam int ZONE_W   = 10;
  localparam int CODE_W   = 8;
  localparam int FX_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // Wide enough for a sum of two Q16.8 values and the scaled pixel position
  localparam int COORD_W = FX_W + 2;
  localparam int ONE_FX  = 1 << FRAC_BITS;

  localparam logic [ZONE_W-1:0] ZONE_RESET       = ZONE_W'(1);
  localparam logic [CODE_W-1:0] BACKGROUND_RESET = CODE_W'(32);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } rrfo_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_WIDTH  = 2'd0,
    CFG_ZONE_HEIGHT = 2'd1,
    CFG_BACKGROUND  = 2'd2,
    CFG_UNUSED      = 2'd3
  } rrfo_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_READ,
    ST_REPLY
  } rrfo_state_t;

  typedef struct packed {
    logic [1:0]             action;
    logic                   filled;
    logic signed [FX_W-1:0] rect_x;
    logic signed [FX_W-1:0] rect_y;
    logic signed [FX_W-1:0] rect_width;
    logic signed [FX_W-1:0] rect_height;
    logic [CODE_W-1:0]      color;
    logic [COL_W-1:0]       pixel_col;
    logic [ROW_W-1:0]       pixel_row;
  } rrfo_in_t;

  typedef struct packed {
    logic              status;
    logic [CODE_W-1:0] pixel_value;
  } rrfo_out_t;

  // Edge thresholds of one rectangle, all in scaled pixel units
  typedef struct packed {
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] x_lo1;
    logic signed [COORD_W-1:0] x_hi1;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] y_hi;
    logic signed [COORD_W-1:0] y_lo1;
    logic signed [COORD_W-1:0] y_hi1;
    logic                      filled;
  } rrfo_bounds_t;

  // Frame buffer access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } rrfo_mem_req_t;

endpackage

`default_nettype wire

[rtl/core/rrfo_fb_ram.sv]
`default_nettype none

module rrfo_fb_ram (
  input  wire                    clk,
  input  wire rrfo_pkg::rrfo_mem_req_t mem_req,
  output logic [rrfo_pkg::CODE_W-1:0] rd_data
);
  import rrfo_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rrfo_cover.sv]
`default_nettype none

module rrfo_cover (
  input  wire rrfo_pkg::rrfo_bounds_t bounds,
  input  wire [rrfo_pkg::COL_W-1:0]   col,
  input  wire [rrfo_pkg::ROW_W-1:0]   row,
  output logic                        paint
);
  import rrfo_pkg::*;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic x_in, y_in, x_edge, y_edge;

  always_comb begin
    px = $signed({{(COORD_W-COL_W-FRAC_BITS){1'b0}}, col, {FRAC_BITS{1'b0}}});
    py = $signed({{(COORD_W-ROW_W-FRAC_BITS){1'b0}}, row, {FRAC_BITS{1'b0}}});
    x_in   = (px >= bounds.x_lo) && (px <= bounds.x_hi);
    y_in   = (py >= bounds.y_lo) && (py <= bounds.y_hi);
    // closer than one pixel unit to an edge
    x_edge = (px < bounds.x_lo1) || (px > bounds.x_hi1);
    y_edge = (py < bounds.y_lo1) || (py > bounds.y_hi1);
    paint  = x_in && y_in && (bounds.filled || x_edge || y_edge);
  end

endmodule

`default_nettype wire

[rtl/core/rectangle_raster_fill_outline.sv]
`default_nettype none

// Rectangle fill and outline rasterizer over a 512 x 512 character frame
// buffer held in one single-port-write, single-port-read synchronous memory.
// Issue a request with start while busy is low; the block answers every
// request with exactly one response, shown on out_rsp for a single cycle
// while out_strobe is high. The receiver cannot stall that response, so
// sample it when the strobe is seen. A clear runs the sweep and reply
// states and a valid draw the setup, sweep and reply states; the sweep
// visits one pixel per cycle through the memory write port. A read runs
// the read and reply states (one memory read), and a rejected draw or an
// unused action code goes straight to reply. busy drops in the cycle the
// strobe rises, so a new request may be issued while the previous response
// is still showing. Write configuration only while busy is low.
// The frame buffer holds no defined content after reset: clear it before
// reading.
module rectangle_raster_fill_outline (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire rrfo_pkg::rrfo_in_t           in_req,
  output logic                              out_strobe,
  output rrfo_pkg::rrfo_out_t               out_rsp,
  input  wire                               cfg_we,
  input  wire [rrfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rrfo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rrfo_pkg::*;

  // Configuration registers
  logic [ZONE_W-1:0] zone_width_r;
  logic [ZONE_W-1:0] zone_height_r;
  logic [CODE_W-1:0] background_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_width_r  <= ZONE_RESET;
      zone_height_r <= ZONE_RESET;
      background_r  <= BACKGROUND_RESET;
    end else if (cfg_we) begin
      case (rrfo_cfg_idx_t'(cfg_index))
        CFG_ZONE_WIDTH:  zone_width_r  <= cfg_wdata[ZONE_W-1:0];
        CFG_ZONE_HEIGHT: zone_height_r <= cfg_wdata[ZONE_W-1:0];
        CFG_BACKGROUND:  background_r  <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and row in use: zero counts as one, clamp to the frame size
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (zone_width_r == '0) begin
      col_last = '0;
    end else if (zone_width_r > ZONE_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(zone_width_r - ZONE_W'(1));
    end
    if (zone_height_r == '0) begin
      row_last = '0;
    end else if (zone_height_r > ZONE_W'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(zone_height_r - ZONE_W'(1));
    end
  end

  // Sequencer state
  rrfo_state_t      state_r, state_nxt;
  rrfo_in_t         req_r, req_nxt;
  rrfo_bounds_t     bounds_r, bounds_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  rrfo_out_t        out_rsp_r, out_rsp_nxt;

  rrfo_mem_req_t     mem_req;
  logic [CODE_W-1:0] rd_data;
  logic              paint;

  logic size_bad;
  logic last_col, last_row;

  rrfo_fb_ram u_fb_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  rrfo_cover u_cover (
    .bounds (bounds_r),
    .col    (col_r),
    .row    (row_r),
    .paint  (paint)
  );

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    bounds_nxt     = bounds_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    status_nxt     = status_r;
    hit_nxt        = hit_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    mem_req        = '0;
    mem_req.waddr  = {row_r, col_r};
    mem_req.raddr  = {req_r.pixel_row, req_r.pixel_col};

    size_bad = (in_req.rect_width <= 0) || (in_req.rect_height <= 0);
    last_col = (col_r == col_last);
    last_row = (row_r == row_last);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          col_nxt    = '0;
          row_nxt    = '0;
          status_nxt = 1'b0;
          hit_nxt    = 1'b0;
          case (rrfo_action_t'(in_req.action))
            ACT_CLEAR: state_nxt = ST_SWEEP;
            ACT_DRAW: begin
              // reject a nonpositive size without touching the buffer
              if (size_bad) begin
                status_nxt = 1'b1;
                state_nxt  = ST_REPLY;
              end else begin
                state_nxt = ST_SETUP;
              end
            end
            ACT_READ: state_nxt = ST_READ;
            default:  state_nxt = ST_REPLY;
          endcase
        end
      end

      ST_SETUP: begin
        // precompute edge thresholds so the sweep only compares
        bounds_nxt.x_lo   = COORD_W'(req_r.rect_x);
        bounds_nxt.x_hi   = COORD_W'(req_r.rect_x) + COORD_W'(req_r.rect_width);
        bounds_nxt.x_lo1  = COORD_W'(req_r.rect_x) + COORD_W'(ONE_FX);
        bounds_nxt.x_hi1  = COORD_W'(req_r.rect_x) + COORD_W'(req_r.rect_width)
                            - COORD_W'(ONE_FX);
        bounds_nxt.y_lo   = COORD_W'(req_r.rect_y);
        bounds_nxt.y_hi   = COORD_W'(req_r.rect_y) + COORD_W'(req_r.rect_height);
        bounds_nxt.y_lo1  = COORD_W'(req_r.rect_y) + COORD_W'(ONE_FX);
        bounds_nxt.y_hi1  = COORD_W'(req_r.rect_y) + COORD_W'(req_r.rect_height)
                            - COORD_W'(ONE_FX);
        bounds_nxt.filled = req_r.filled;
        state_nxt = ST_SWEEP;
      end

      ST_SWEEP: begin
        // one pixel per cycle, row-major over the zone in use
        if (rrfo_action_t'(req_r.action) == ACT_CLEAR) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = background_r;
        end else begin
          mem_req.we    = paint;
          mem_req.wdata = req_r.color;
        end
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            state_nxt = ST_REPLY;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end

      ST_READ: begin
        // read data lands in rd_data in the reply cycle
        hit_nxt    = (req_r.pixel_col <= col_last) && (req_r.pixel_row <= row_last);
        mem_req.re = 1'b1;
        state_nxt  = ST_REPLY;
      end

      ST_REPLY: begin
        out_strobe_nxt          = 1'b1;
        out_rsp_nxt.status      = status_r;
        out_rsp_nxt.pixel_value = hit_r ? rd_data : '0;
        state_nxt               = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    bounds_r  <= bounds_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

`default_nettype wire

[rtl/core/rrfo_checker.sv]
`default_nettype none

module rrfo_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      start,
  input wire                      busy,
  input wire rrfo_pkg::rrfo_in_t  in_req,
  input wire                      out_strobe,
  input wire rrfo_pkg::rrfo_out_t out_rsp
);
  import rrfo_pkg::*;

  // a request is always answered through a busy phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // the response appears exactly as the busy phase ends
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a response");

  // responses are single-cycle strobes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("response strobe held for two cycles");

  // a rejected draw never carries pixel data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.status) |-> (out_rsp.pixel_value == '0))
    else $error("rejected request returned pixel data");

  // an unused action code goes straight to the reply state and is answered
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.action == ACT_NONE)) |-> ##2 out_strobe)
    else $error("unused action not answered in time");

endmodule

bind rectangle_raster_fill_outline rrfo_checker u_rrfo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

`default_nettype wire

[tb/tb_rectangle_raster_fill_outline.sv]
module tb_rectangle_raster_fill_outline;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfo_pkg::*;

  // Run shape
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 64;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;
  // Slowest request sweeps a full 512 x 512 zone; allow several times that
  localparam int WATCHDOG_LIMIT = 4 * (DEPTH + 2);

  // One row of the directed plan: either a register write or a request,
  // with the answer typed in where it is obvious
  typedef struct {
    bit                    is_cfg;
    rrfo_cfg_idx_t         idx;
    logic [CFG_DATA_W-1:0] data;
    rrfo_in_t              req;
    bit                    has_want;
    rrfo_out_t             want;
  } plan_step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  rrfo_in_t              in_req;
  logic                  out_strobe;
  rrfo_out_t             out_rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rectangle_raster_fill_outline dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the block: registers, frame contents and which pixels hold a
  // defined code (reads of undefined pixels must never be issued)
  logic [ZONE_W-1:0] zone_w;
  logic [ZONE_W-1:0] zone_h;
  logic [CODE_W-1:0] bg_code;
  logic [CODE_W-1:0] frame_model [DEPTH];
  bit                painted_mask [DEPTH];

  rrfo_out_t   pending_results [$];
  plan_step_t  plan [$];

  int burst_left;
  int fail_count;
  int results_seen;
  int n_clear, n_draw, n_rejected, n_read, n_idle, n_phase;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Zone registers saturate: 0 acts as 1, anything past the maximum as the max
  function automatic int zone_cols();
    if (zone_w == 0) return 1;
    if (zone_w > MAX_WIDTH) return MAX_WIDTH;
    return int'(zone_w);
  endfunction

  function automatic int zone_rows();
    if (zone_h == 0) return 1;
    if (zone_h > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(zone_h);
  endfunction

  // Apply one request to the shadow frame and return the answer it earns
  function automatic rrfo_out_t rasterize_request(rrfo_in_t q);
    rrfo_out_t res;
    int        cols, rows, r, c;
    longint    rx, ry, rw, rh, right, bottom, px, py;
    bit        yedge, edge_hit;
    res  = '0;
    cols = zone_cols();
    rows = zone_rows();
    case (q.action)
      ACT_CLEAR: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++) begin
            frame_model[r * MAX_WIDTH + c]  = bg_code;
            painted_mask[r * MAX_WIDTH + c] = 1'b1;
          end
      end
      ACT_DRAW: begin
        rx = longint'(signed'(q.rect_x));
        ry = longint'(signed'(q.rect_y));
        rw = longint'(signed'(q.rect_width));
        rh = longint'(signed'(q.rect_height));
        if (rw <= 0 || rh <= 0) begin
          res.status = 1'b1;
        end else begin
          right  = rx + rw;
          bottom = ry + rh;
          for (r = 0; r < rows; r++) begin
            py = longint'(r) * ONE_FX;
            if (py < ry || py > bottom) continue;
            yedge = (py - ry) < ONE_FX || (bottom - py) < ONE_FX;
            for (c = 0; c < cols; c++) begin
              px = longint'(c) * ONE_FX;
              if (px < rx || px > right) continue;
              edge_hit = yedge || (px - rx) < ONE_FX || (right - px) < ONE_FX;
              if (q.filled || edge_hit) begin
                frame_model[r * MAX_WIDTH + c]  = q.color;
                painted_mask[r * MAX_WIDTH + c] = 1'b1;
              end
            end
          end
        end
      end
      ACT_READ: begin
        if (q.pixel_col < cols && q.pixel_row < rows)
          res.pixel_value = frame_model[q.pixel_row * MAX_WIDTH + q.pixel_col];
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Directed plan helpers
  // ---------------------------------------------------------------------

  function automatic plan_step_t cfg_step(rrfo_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    plan_step_t s;
    s.is_cfg   = 1'b1;
    s.idx      = idx;
    s.data     = data;
    s.req      = '0;
    s.has_want = 1'b0;
    s.want     = '0;
    return s;
  endfunction

  function automatic plan_step_t req_step(rrfo_action_t act, logic fill,
                                          logic [FX_W-1:0] x, logic [FX_W-1:0] y,
                                          logic [FX_W-1:0] w, logic [FX_W-1:0] h,
                                          logic [CODE_W-1:0] color,
                                          logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    plan_step_t s;
    s.is_cfg          = 1'b0;
    s.idx             = CFG_ZONE_WIDTH;
    s.data            = '0;
    s.req             = '0;
    s.has_want        = 1'b0;
    s.want            = '0;
    s.req.action      = act;
    s.req.filled      = fill;
    s.req.rect_x      = x;
    s.req.rect_y      = y;
    s.req.rect_width  = w;
    s.req.rect_height = h;
    s.req.color       = color;
    s.req.pixel_col   = c;
    s.req.pixel_row   = r;
    return s;
  endfunction

  function automatic plan_step_t known(plan_step_t s, logic st, logic [CODE_W-1:0] pix);
    s.has_want         = 1'b1;
    s.want.status      = st;
    s.want.pixel_value = pix;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Issue one request in bursts; hold start until the block takes it, then
  // log the expected answer (typed one if given, else the predicted one)
  task automatic send_request(rrfo_in_t q, bit has_want, rrfo_out_t want);
    int        gap;
    rrfo_out_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Long bursts now and then give stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    start  <= 1'b1;
    in_req <= q;
    do @(posedge clk); while (busy);
    predicted = rasterize_request(q);
    pending_results.push_back(has_want ? want : predicted);
    case (q.action)
      ACT_CLEAR: n_clear++;
      ACT_DRAW: begin
        n_draw++;
        if (predicted.status) n_rejected++;
      end
      ACT_READ: n_read++;
      default: n_idle++;
    endcase
  endtask

  // Drop start and wait until every answer is in and the block is idle
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(rrfo_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ZONE_WIDTH:  zone_w  = data;
      CFG_ZONE_HEIGHT: zone_h  = data;
      CFG_BACKGROUND:  bg_code = data[CODE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a read that never touches an undefined pixel: either outside the
  // zone, or a pixel that a clear or draw has already set
  task automatic pick_read(output logic [COL_W-1:0] c, output logic [ROW_W-1:0] r,
                           output bit ok);
    int cols, rows, tries;
    cols = zone_cols();
    rows = zone_rows();
    ok   = 1'b0;
    c    = '0;
    r    = '0;
    if ($urandom_range(0, 4) == 0 && (cols < MAX_WIDTH || rows < MAX_HEIGHT)) begin
      if (cols < MAX_WIDTH && (rows == MAX_HEIGHT || $urandom_range(0, 1) == 1)) begin
        c = COL_W'($urandom_range(cols, MAX_WIDTH - 1));
        r = ROW_W'($urandom);
      end else begin
        c = COL_W'($urandom);
        r = ROW_W'($urandom_range(rows, MAX_HEIGHT - 1));
      end
      ok = 1'b1;
    end else begin
      for (tries = 0; tries < 8 && !ok; tries++) begin
        c  = COL_W'($urandom_range(0, cols - 1));
        r  = ROW_W'($urandom_range(0, rows - 1));
        ok = painted_mask[r * MAX_WIDTH + c];
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so take every strobe
  // ---------------------------------------------------------------------

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk) begin : check_results
    rrfo_out_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("answer %0d arrived with none expected: status=%0d pixel=%02h",
                               results_seen, out_rsp.status, out_rsp.pixel_value));
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status || out_rsp.pixel_value !== want.pixel_value)
          note_failure($sformatf(
            "answer %0d mismatch: expected status=%0d pixel=%02h, got status=%0d pixel=%02h",
            results_seen, want.status, want.pixel_value, out_rsp.status, out_rsp.pixel_value));
      end
    end
  end

  // Watchdog: end the run if nothing is taken or answered for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || out_strobe || (start && !busy)) idle = 0;
      else idle++;
    end
    $display("[%0t] watchdog expired, %0d answers outstanding", $time,
             pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin : stimulus
    rrfo_in_t         q;
    logic [127:0]     noise;
    logic [COL_W-1:0] rc;
    logic [ROW_W-1:0] rr;
    bit               read_ok, lead_clear;
    int               random_sent, phase_len, i, kind, cols, rows, x, y, w, h;
    rrfo_out_t        none_want;

    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ZONE_WIDTH;
    cfg_wdata = '0;
    none_want = '0;

    // Shadow state after reset
    zone_w       = ZONE_RESET;
    zone_h       = ZONE_RESET;
    bg_code      = BACKGROUND_RESET;
    burst_left   = 0;
    fail_count   = 0;
    results_seen = 0;
    random_sent  = 0;
    foreach (painted_mask[k]) painted_mask[k] = 1'b0;

    // Directed plan: small zone first, then the zone extremes
    plan.push_back(cfg_step(CFG_ZONE_WIDTH, 10'd8));
    plan.push_back(cfg_step(CFG_ZONE_HEIGHT, 10'd6));
    plan.push_back(cfg_step(CFG_BACKGROUND, 10'h02E));
    plan.push_back(cfg_step(CFG_UNUSED, 10'h3FF));
    plan.push_back(known(req_step(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h2E));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 7, 5), 0, 8'h2E));
    // Reads outside the zone answer zero
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 8, 0), 0, 8'h00));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 9'h1FF, 9'h1FF), 0, 8'h00));
    // Nonpositive sizes are rejected
    plan.push_back(known(req_step(ACT_DRAW, 1, 0, 0, 0, 24'h000400, 8'h41, 0, 0), 1, 8'h00));
    plan.push_back(known(req_step(ACT_DRAW, 1, 0, 0, 24'h000400, 24'h800000, 8'h41, 0, 0),
                         1, 8'h00));
    plan.push_back(known(req_step(ACT_DRAW, 0, 0, 0, 24'h800000, 24'h000000, 8'h41, 0, 0),
                         1, 8'h00));
    // Filled box on whole pixels, then an outline on half-pixel edges
    plan.push_back(known(req_step(ACT_DRAW, 1, 24'h000100, 24'h000100, 24'h000300, 24'h000200,
                                  8'h52, 0, 0), 0, 8'h00));
    plan.push_back(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 2, 2));
    plan.push_back(req_step(ACT_DRAW, 0, 24'h000080, 24'h000080, 24'h000500, 24'h000400,
                            8'h72, 0, 0));
    plan.push_back(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 3, 2));
    plan.push_back(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 1, 1));
    plan.push_back(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 5, 4));
    // Unused action code is ignored
    plan.push_back(known(req_step(ACT_NONE, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                  8'hFF, 9'h1FF, 9'h1FF), 0, 8'h00));
    // Coordinate extremes
    plan.push_back(req_step(ACT_DRAW, 1, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                            8'hFF, 0, 0));
    plan.push_back(req_step(ACT_DRAW, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                            8'hFF, 0, 0));
    plan.push_back(known(req_step(ACT_DRAW, 1, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 8'h00, 0, 0),
                         0, 8'h00));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 7, 5), 0, 8'h00));
    // Zone registers of zero act as one and past the limits saturate; background keeps its low byte
    plan.push_back(cfg_step(CFG_ZONE_WIDTH, 10'd0));
    plan.push_back(cfg_step(CFG_ZONE_HEIGHT, 10'h3FF));
    plan.push_back(cfg_step(CFG_BACKGROUND, 10'h3FF));
    plan.push_back(known(req_step(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 9'h1FF), 0, 8'hFF));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0), 0, 8'h00));
    plan.push_back(cfg_step(CFG_ZONE_WIDTH, 10'h3FF));
    plan.push_back(cfg_step(CFG_ZONE_HEIGHT, 10'd0));
    plan.push_back(known(req_step(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
    plan.push_back(known(req_step(ACT_READ, 0, 0, 0, 0, 0, 0, 9'h1FF, 0), 0, 8'hFF));

    // Hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan; register writes only with the block idle
    foreach (plan[p]) begin
      if (plan[p].is_cfg) begin
        drain_pipeline();
        write_reg(plan[p].idx, plan[p].data);
      end else begin
        send_request(plan[p].req, plan[p].has_want, plan[p].want);
      end
    end

    // Random phases: new zone and background, then a mix of requests. The
    // drain before each phase also pauses the sender until all answers are in.
    while (random_sent < RANDOM_ITEMS) begin
      drain_pipeline();
      n_phase++;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_ZONE_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
          1:       write_reg(CFG_ZONE_WIDTH, CFG_DATA_W'($urandom_range(MAX_WIDTH, 1023)));
          default: write_reg(CFG_ZONE_WIDTH, CFG_DATA_W'($urandom_range(1, 24)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        // Keep the swept area small when the width went to its extreme
        if (zone_cols() > 24)
          write_reg(CFG_ZONE_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
        else if (zone_cols() <= 2)
          write_reg(CFG_ZONE_HEIGHT, CFG_DATA_W'($urandom_range(1, 1023)));
        else
          write_reg(CFG_ZONE_HEIGHT, CFG_DATA_W'($urandom_range(1, 16)));
      end
      if (zone_cols() * zone_rows() > 1024) write_reg(CFG_ZONE_HEIGHT, 10'd1);
      if ($urandom_range(0, 1) == 1) write_reg(CFG_BACKGROUND, CFG_DATA_W'($urandom));

      cols       = zone_cols();
      rows       = zone_rows();
      phase_len  = $urandom_range(6, 16);
      lead_clear = ($urandom_range(0, 3) != 0);
      for (i = 0; i < phase_len; i++) begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        q     = noise[$bits(rrfo_in_t)-1:0];
        kind  = (i == 0 && lead_clear) ? 0 : $urandom_range(0, 99);
        if (kind < 8) begin
          q.action = ACT_CLEAR;
        end else if (kind < 48) begin
          // Well-formed rectangle around the zone, snapped to pixels at times
          q.action = ACT_DRAW;
          x = int'($urandom_range(0, (cols + 3) * ONE_FX)) - 2 * ONE_FX;
          y = int'($urandom_range(0, (rows + 3) * ONE_FX)) - 2 * ONE_FX;
          if ($urandom_range(0, 2) == 0) begin
            x = x & ~(ONE_FX - 1);
            y = y & ~(ONE_FX - 1);
          end
          w = ($urandom_range(0, 1) == 1) ? ONE_FX * $urandom_range(1, cols + 2)
                                           : $urandom_range(1, (cols + 3) * ONE_FX);
          h = ($urandom_range(0, 1) == 1) ? ONE_FX * $urandom_range(1, rows + 2)
                                           : $urandom_range(1, (rows + 3) * ONE_FX);
          q.rect_x      = x[FX_W-1:0];
          q.rect_y      = y[FX_W-1:0];
          q.rect_width  = w[FX_W-1:0];
          q.rect_height = h[FX_W-1:0];
        end else if (kind < 58) begin
          // Full-range fields, mostly off the zone or rejected
          q.action = ACT_DRAW;
        end else if (kind < 66) begin
          q.action = ACT_DRAW;
          w = -int'($urandom_range(0, 8388608));
          case ($urandom_range(0, 2))
            0:       q.rect_width  = w[FX_W-1:0];
            1:       q.rect_height = w[FX_W-1:0];
            default: begin
              q.rect_width  = w[FX_W-1:0];
              q.rect_height = 24'h000000;
            end
          endcase
        end else if (kind < 94) begin
          pick_read(rc, rr, read_ok);
          if (read_ok) begin
            q.action    = ACT_READ;
            q.pixel_col = rc;
            q.pixel_row = rr;
          end else begin
            q.action = ACT_CLEAR;
          end
        end else begin
          q.action = ACT_NONE;
        end
        send_request(q, 1'b0, none_want);
        if (q.action != ACT_NONE) random_sent++;
      end
    end

    // Let every answer arrive, then settle
    drain_pipeline();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d answers never arrived", pending_results.size()));

    $display("Ran %0d clears, %0d draws (%0d rejected), %0d reads, %0d unused codes",
             n_clear, n_draw, n_rejected, n_read, n_idle);
    $display("over %0d random zone settings; %0d answers checked, %0d failures",
             n_phase, results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
